// File: src/lkct_pkg.sv
// package for the lru key cache tracker
// widths, capacity and reset values used by the tracker top level; no dependencies
package lkct_pkg;
   localparam int CAPACITY = 1024;
   localparam int KEY_W    = 32;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int OCC_W    = $clog2(CAPACITY + 1);

   localparam logic [OCC_W-1:0] CAP_RESET = OCC_W'(CAPACITY);
   localparam logic [OCC_W-1:0] CAP_MAX   = OCC_W'(CAPACITY);
   localparam logic [OCC_W-1:0] CAP_MIN   = OCC_W'(1);
endpackage

// File: src/lkct_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read port, read data holds while re is low; no dependencies
module lkct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: src/lru_key_cache_tracker.sv
// top level of the lru key cache tracker
// uses lkct_pkg and three lkct_ram instances (keys, older links, newer links)
//
//  channel   ports                                  handshake
//  request   start, busy, req_key                   start && !busy
//  response  rsp_strobe, rsp_miss, rsp_evicted_*,   rsp_strobe, one cycle
//            rsp_warm
//  csr       csr_valid, csr_ready, csr_data         csr_valid && csr_ready
//
// from accept to result an item first scans the occupied slots, then inserts into the next
// unused slot, evicts the oldest slot when full, or on a hit relinks the slot as newest unless it is;
// the key scan reads one slot per cycle from the key ram; start is taken again in the
// result cycle. slots below the occupancy count are valid, so reset needs no clearing pass.
// reset is synchronous; the receiver cannot stall, each result shows for one cycle.
module lru_key_cache_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lkct_pkg::KEY_W-1:0]  req_key,
   output logic                        rsp_strobe,
   output logic                        rsp_miss,
   output logic                        rsp_evicted_valid,
   output logic [lkct_pkg::KEY_W-1:0]  rsp_evicted_key,
   output logic                        rsp_warm,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lkct_pkg::OCC_W-1:0]  csr_data
);
   localparam int SW = lkct_pkg::SLOT_W;
   localparam int OW = lkct_pkg::OCC_W;
   localparam int KW = lkct_pkg::KEY_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_HCHK = 3'd2;
   localparam logic [2:0] ST_HW2  = 3'd3;
   localparam logic [2:0] ST_EVCT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [OW-1:0] cap_ff;
   logic [OW-1:0] occ_ff, occ_in;
   logic [SW-1:0] oldest_ff, oldest_in;
   logic [SW-1:0] newest_ff, newest_in;
   logic          warm_ff, warm_in;
   logic [KW-1:0] key_ff;
   logic [OW-1:0] scan_idx_ff, scan_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [SW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [SW-1:0] slot_ff, slot_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_miss_ff, rsp_miss_in;
   logic          rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [KW-1:0] rsp_ev_key_ff, rsp_ev_key_in;

   // ram ports
   logic          key_we, key_re, old_we, old_re, new_we, new_re;
   logic [SW-1:0] key_wa, key_ra, old_wa, old_ra, new_wa, new_ra;
   logic [KW-1:0] key_wd, key_rd;
   logic [SW-1:0] old_wd, old_rd, new_wd, new_rd;

   logic [OW-1:0] eff_cap;

   lkct_ram #(.WIDTH(KW), .DEPTH(lkct_pkg::CAPACITY)) u_key_ram (
      .clock(clock), .we(key_we), .waddr(key_wa), .wdata(key_wd),
      .re(key_re), .raddr(key_ra), .rdata(key_rd)
   );

   lkct_ram #(.WIDTH(SW), .DEPTH(lkct_pkg::CAPACITY)) u_older_ram (
      .clock(clock), .we(old_we), .waddr(old_wa), .wdata(old_wd),
      .re(old_re), .raddr(old_ra), .rdata(old_rd)
   );

   lkct_ram #(.WIDTH(SW), .DEPTH(lkct_pkg::CAPACITY)) u_newer_ram (
      .clock(clock), .we(new_we), .waddr(new_wa), .wdata(new_wd),
      .re(new_re), .raddr(new_ra), .rdata(new_rd)
   );

   // clamp the capacity register into its usable range
   always_comb begin
      eff_cap = cap_ff;
      if (cap_ff == '0) begin
         eff_cap = lkct_pkg::CAP_MIN;
      end else if (cap_ff > lkct_pkg::CAP_MAX) begin
         eff_cap = lkct_pkg::CAP_MAX;
      end
   end

   // sequencer: scan, then relink or evict or insert
   always_comb begin
      state_in        = state_ff;
      occ_in          = occ_ff;
      oldest_in       = oldest_ff;
      newest_in       = newest_ff;
      warm_in         = warm_ff;
      scan_idx_in     = scan_idx_ff;
      cmp_valid_in    = 1'b0;
      cmp_idx_in      = cmp_idx_ff;
      slot_in         = slot_ff;
      rsp_strobe_in   = 1'b0;
      rsp_miss_in     = rsp_miss_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_key_in   = rsp_ev_key_ff;
      key_we = 1'b0; key_wa = '0; key_wd = '0; key_re = 1'b0; key_ra = '0;
      old_we = 1'b0; old_wa = '0; old_wd = '0; old_re = 1'b0; old_ra = '0;
      new_we = 1'b0; new_wa = '0; new_wd = '0; new_re = 1'b0; new_ra = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_valid_ff && key_rd == key_ff) begin
               // hit: fetch the links of the matching slot
               slot_in     = cmp_idx_ff;
               old_re      = 1'b1;
               old_ra      = cmp_idx_ff;
               new_re      = 1'b1;
               new_ra      = cmp_idx_ff;
               rsp_miss_in     = 1'b0;
               rsp_ev_valid_in = 1'b0;
               rsp_ev_key_in   = '0;
               state_in    = ST_HCHK;
            end else if (scan_idx_ff == occ_ff) begin
               rsp_miss_in = 1'b1;
               if (occ_ff >= eff_cap) begin
                  // full: fetch the oldest entry's key and newer link
                  slot_in  = oldest_ff;
                  key_re   = 1'b1;
                  key_ra   = oldest_ff;
                  new_re   = 1'b1;
                  new_ra   = oldest_ff;
                  state_in = ST_EVCT;
               end else begin
                  // insert into the next unused slot
                  key_we = 1'b1;
                  key_wa = occ_ff[SW-1:0];
                  key_wd = key_ff;
                  if (occ_ff == '0) begin
                     oldest_in = occ_ff[SW-1:0];
                  end else begin
                     new_we = 1'b1;
                     new_wa = newest_ff;
                     new_wd = occ_ff[SW-1:0];
                     old_we = 1'b1;
                     old_wa = occ_ff[SW-1:0];
                     old_wd = newest_ff;
                  end
                  newest_in       = occ_ff[SW-1:0];
                  occ_in          = occ_ff + OW'(1);
                  rsp_ev_valid_in = 1'b0;
                  rsp_ev_key_in   = '0;
                  rsp_strobe_in   = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               // read the next slot, compare it next cycle
               key_re       = 1'b1;
               key_ra       = scan_idx_ff[SW-1:0];
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_idx_ff[SW-1:0];
               scan_idx_in  = scan_idx_ff + OW'(1);
            end
         end
         ST_HCHK: begin
            if (occ_ff == OW'(1) || slot_ff == newest_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               // unlink the slot from its neighbors
               if (slot_ff == oldest_ff) begin
                  oldest_in = new_rd;
               end else begin
                  new_we = 1'b1;
                  new_wa = old_rd;
                  new_wd = new_rd;
               end
               old_we   = 1'b1;
               old_wa   = new_rd;
               old_wd   = old_rd;
               state_in = ST_HW2;
            end
         end
         ST_HW2: begin
            // append the slot at the newest end
            new_we        = 1'b1;
            new_wa        = newest_ff;
            new_wd        = slot_ff;
            old_we        = 1'b1;
            old_wa        = slot_ff;
            old_wd        = newest_ff;
            newest_in     = slot_ff;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_EVCT: begin
            // reuse the oldest slot for the new key
            rsp_ev_valid_in = 1'b1;
            rsp_ev_key_in   = key_rd;
            warm_in         = 1'b1;
            key_we          = 1'b1;
            key_wa          = slot_ff;
            key_wd          = key_ff;
            if (occ_ff > OW'(1)) begin
               oldest_in = new_rd;
               new_we    = 1'b1;
               new_wa    = newest_ff;
               new_wd    = slot_ff;
               old_we    = 1'b1;
               old_wa    = slot_ff;
               old_wd    = newest_ff;
               newest_in = slot_ff;
            end else begin
               oldest_in = slot_ff;
               newest_in = slot_ff;
            end
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cap_ff        <= lkct_pkg::CAP_RESET;
         occ_ff        <= '0;
         oldest_ff     <= '0;
         newest_ff     <= '0;
         warm_ff       <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         oldest_ff     <= oldest_in;
         newest_ff     <= newest_in;
         warm_ff       <= warm_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            cap_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         key_ff <= req_key;
      end
      scan_idx_ff     <= scan_idx_in;
      cmp_idx_ff      <= cmp_idx_in;
      slot_ff         <= slot_in;
      rsp_miss_ff     <= rsp_miss_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_key_ff   <= rsp_ev_key_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_miss          = rsp_miss_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_key   = rsp_ev_key_ff;
   assign rsp_warm          = warm_ff;
endmodule
